// File: hdl/tksel_pkg.sv
// Shared types and codes for the top-k score selector.
// Holds the heap entry layout, the output beat layout and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package tksel_pkg;

	// One kept candidate; the layout matches the input tdata (score in the low half).
	typedef struct packed {
		logic [31:0]        doc_id;
		logic signed [31:0] score;
	} entry_t;

	// One result beat as it is handed to the output register.
	typedef struct packed {
		logic   none_found;
		logic   last;
		entry_t entry;
	} out_beat_t;

	// Input command codes.
	localparam logic CMD_OFFER = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_KEEP_COUNT  = 1'b0;
	localparam logic CFG_SCORE_FLOOR = 1'b1;

	// Register reset values.
	localparam logic [4:0]         KEEP_COUNT_RST  = 5'd16;
	localparam logic signed [31:0] SCORE_FLOOR_RST = 32'sd0;

endpackage

// File: hdl/tksel_heap_ram.sv
// Heap storage: a synchronous memory with one write port and two read ports.
// Read data is registered and appears in the cycle after the address is given with rd_en set.
// Depends on tksel_pkg for the entry layout.
`timescale 1ns / 1ps

module tksel_heap_ram #(
	parameter int MAX_KEEP = 16,
	parameter int AW       = 4
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr_a,
	input  logic [AW-1:0]   rd_addr_b,
	output tksel_pkg::entry_t rd_data_a,
	output tksel_pkg::entry_t rd_data_b,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  tksel_pkg::entry_t wr_data
);
	import tksel_pkg::*;

	entry_t mem_q [MAX_KEEP];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// File: hdl/tksel_out_reg.sv
// Output register for result beats, decoupling the controller from the consumer.
// It reports whether it can take a new beat in this cycle.
// Depends on tksel_pkg for the beat layout.
`timescale 1ns / 1ps

module tksel_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tksel_pkg::out_beat_t beat,
	output logic                free,
	output logic                tvalid,
	input  logic                tready,
	output logic [63:0]         tdata,   // out_score [31:0], out_doc_id [63:32]
	output logic                tlast,
	output logic                tuser    // none_found
);
	import tksel_pkg::*;

	logic      valid_q;
	out_beat_t beat_q;

	// The register can be loaded when it is empty or being emptied this cycle.
	assign free = !valid_q || tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= beat;
		end
	end

	assign tvalid = valid_q;
	assign tdata  = beat_q.entry;
	assign tlast  = beat_q.last;
	assign tuser  = beat_q.none_found;

endmodule

// File: hdl/tksel_ctrl.sv
// Heap controller: sift-up on insert, root replace with sift-down, and drain by
// in-place heap sort followed by a readout from slot zero upward.
// Depends on tksel_pkg; drives tksel_heap_ram and tksel_out_reg.
`timescale 1ns / 1ps

module tksel_ctrl #(
	parameter int MAX_KEEP = 16,
	parameter int AW       = 4,
	parameter int CW       = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input item
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_command,
	input  tksel_pkg::entry_t   in_entry,
	// Configuration
	input  logic [4:0]          keep_count,
	input  logic signed [31:0]  score_floor,
	// Heap memory
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr_a,
	output logic [AW-1:0]       rd_addr_b,
	input  tksel_pkg::entry_t   rd_data_a,
	input  tksel_pkg::entry_t   rd_data_b,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output tksel_pkg::entry_t   wr_data,
	// Output register
	output logic                out_load,
	output tksel_pkg::out_beat_t out_beat,
	input  logic                out_free
);
	import tksel_pkg::*;

	localparam int IW = CW + 1;
	localparam int KW = (CW > 5) ? CW : 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RT_RD,
		ST_RT_CMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_DR_START,
		ST_DR_RD,
		ST_DR_SWAP,
		ST_EM_RD,
		ST_EM_LD
	} state_t;

	state_t          state_q;
	entry_t          cur_q;
	logic [AW-1:0]   node_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   fill_q;
	logic            draining_q;
	logic [AW-1:0]   emit_idx_q;

	logic [KW-1:0]   keep_ext;
	logic [KW-1:0]   cap;
	logic            full;
	logic            accept;
	logic            pass_floor;
	logic [IW-1:0]   left;
	logic [IW-1:0]   right;
	logic            left_ok;
	logic            right_ok;
	logic [AW-1:0]   parent;
	logic            up_swap;
	logic            pick_left;
	logic            pick_right;
	logic signed [31:0] pick_score;
	logic            moved;
	entry_t          pick_entry;
	logic [AW-1:0]   pick_idx;
	logic [CW-1:0]   cnt_m1;
	logic            emit_last;

	// Capacity: zero keeps one entry, anything above the storage keeps all of it.
	always_comb begin
		keep_ext = KW'(keep_count);
		if (keep_count == 5'd0) begin
			cap = KW'(1);
		end else if (keep_ext > KW'(MAX_KEEP)) begin
			cap = KW'(MAX_KEEP);
		end else begin
			cap = keep_ext;
		end
	end
	assign full = KW'(fill_q) >= cap;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign pass_floor = in_entry.score >= score_floor;

	// Tree navigation around the current node.
	assign left     = (IW'(node_q) << 1) + IW'(1);
	assign right    = left + IW'(1);
	assign left_ok  = left < IW'(count_q);
	assign right_ok = right < IW'(count_q);
	assign parent   = (node_q - AW'(1)) >> 1;
	assign cnt_m1   = count_q - CW'(1);

	// Sift-up keeps moving while the new entry is strictly below its parent.
	assign up_swap = cur_q.score < rd_data_a.score;

	// Sift-down: left child if strictly smaller, then right if smaller than that pick.
	assign pick_left  = left_ok && (rd_data_a.score < cur_q.score);
	assign pick_score = pick_left ? rd_data_a.score : cur_q.score;
	assign pick_right = right_ok && (rd_data_b.score < pick_score);
	assign moved      = pick_left || pick_right;
	assign pick_entry = pick_right ? rd_data_b : rd_data_a;
	assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];

	assign emit_last = CW'(emit_idx_q) == (fill_q - CW'(1));

	// Memory and output requests for the current state.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = node_q;
		wr_data   = cur_q;
		out_load  = 1'b0;
		out_beat  = '0;
		unique case (state_q)
			ST_RT_RD: begin
				rd_en = 1'b1;
			end
			ST_UP_RD: begin
				if (node_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en     = 1'b1;
					rd_addr_a = parent;
				end
			end
			ST_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = up_swap ? rd_data_a : cur_q;
			end
			ST_DN_RD: begin
				if (!left_ok) begin
					wr_en = 1'b1;
				end else begin
					rd_en     = 1'b1;
					rd_addr_a = left[AW-1:0];
					rd_addr_b = right[AW-1:0];
				end
			end
			ST_DN_CMP: begin
				wr_en   = 1'b1;
				wr_data = moved ? pick_entry : cur_q;
			end
			ST_DR_START: begin
				if (fill_q == '0 && out_free) begin
					out_load            = 1'b1;
					out_beat.last       = 1'b1;
					out_beat.none_found = 1'b1;
				end
			end
			ST_DR_RD: begin
				rd_en     = 1'b1;
				rd_addr_b = cnt_m1[AW-1:0];
			end
			ST_DR_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = cnt_m1[AW-1:0];
				wr_data = rd_data_a;
			end
			ST_EM_RD: begin
				if (out_free) begin
					rd_en     = 1'b1;
					rd_addr_a = emit_idx_q;
				end
			end
			ST_EM_LD: begin
				out_load       = 1'b1;
				out_beat.entry = rd_data_a;
				out_beat.last  = emit_last;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			draining_q <= 1'b0;
			count_q    <= '0;
			node_q     <= '0;
			emit_idx_q <= '0;
			cur_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_command == CMD_DRAIN) begin
							state_q <= ST_DR_START;
						end else if (pass_floor) begin
							cur_q <= in_entry;
							if (!full) begin
								node_q  <= fill_q[AW-1:0];
								fill_q  <= fill_q + CW'(1);
								state_q <= ST_UP_RD;
							end else if (fill_q != '0) begin
								state_q <= ST_RT_RD;
							end
						end
					end
				end
				ST_RT_RD: begin
					state_q <= ST_RT_CMP;
				end
				ST_RT_CMP: begin
					if (cur_q.score > rd_data_a.score) begin
						node_q     <= '0;
						count_q    <= fill_q;
						draining_q <= 1'b0;
						state_q    <= ST_DN_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_UP_RD: begin
					state_q <= (node_q == '0) ? ST_IDLE : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					if (up_swap) begin
						node_q  <= parent;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DN_RD: begin
					if (!left_ok) begin
						state_q <= draining_q ? ST_DR_RD : ST_IDLE;
					end else begin
						state_q <= ST_DN_CMP;
					end
				end
				ST_DN_CMP: begin
					if (moved) begin
						node_q  <= pick_idx;
						state_q <= ST_DN_RD;
					end else begin
						state_q <= draining_q ? ST_DR_RD : ST_IDLE;
					end
				end
				ST_DR_START: begin
					if (fill_q == '0) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						count_q    <= fill_q;
						draining_q <= 1'b1;
						state_q    <= ST_DR_RD;
					end
				end
				ST_DR_RD: begin
					state_q <= ST_DR_SWAP;
				end
				ST_DR_SWAP: begin
					// Root goes to the freed slot; the last entry restarts at the root.
					cur_q   <= rd_data_b;
					count_q <= cnt_m1;
					node_q  <= '0;
					if (cnt_m1 == '0) begin
						emit_idx_q <= '0;
						state_q    <= ST_EM_RD;
					end else begin
						state_q <= ST_DN_RD;
					end
				end
				ST_EM_RD: begin
					if (out_free) begin
						state_q <= ST_EM_LD;
					end
				end
				ST_EM_LD: begin
					if (emit_last) begin
						fill_q     <= '0;
						draining_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						emit_idx_q <= emit_idx_q + AW'(1);
						state_q    <= ST_EM_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The fill count never exceeds the storage.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_KEEP))
		else $error("fill count beyond heap depth");

	// A read and a write never target the same entry in one cycle.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr_a && wr_addr != rd_addr_b))
		else $error("heap read and write collide");

	// A beat is only loaded when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output beat overwritten");

	// Finishing a drain leaves the heap empty.
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(draining_q) |-> (fill_q == '0))
		else $error("drain ended with entries left");
`endif

endmodule

// File: hdl/top_k_score_selector_unit.sv
// Top level of the top-k score selector: configuration registers and the
// heap controller, heap memory and output register. Depends on tksel_pkg.
`timescale 1ns / 1ps

// Keeps the best keep_count candidates (Q16.16 score, document id) in a min-heap
// held in a synchronous RAM of MAX_KEEP entries, one item at a time. An offer
// below the score floor is dropped as it is taken, and one that does not beat
// the weakest kept entry of a full heap is dropped after a root read and compare.
// An insert starts at the next free slot and climbs while strictly below its
// parent; a root replacement descends up to log2(MAX_KEEP) levels. Each level
// climbed or descended is one RAM read and one compare-and-write. A drain sorts
// the heap in place (each pop moves the root to the last slot, then descends),
// then sends the entries best first while the output register is free, tlast on
// the final one; an empty heap gives a single beat with tuser (none_found) and
// tlast set. The memory needs no clearing after reset. Configuration is written
// by the user only while the block is idle; the block does not enforce this.
module top_k_score_selector_unit #(
	parameter int MAX_KEEP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // score [31:0], doc_id [63:32]
	input  logic        s_axis_tuser,   // command
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_score [31:0], out_doc_id [63:32]
	output logic        m_axis_tlast,   // last
	output logic        m_axis_tuser,   // none_found
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import tksel_pkg::*;

	localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int CW = $clog2(MAX_KEEP + 1);

	logic [4:0]         keep_count_q;
	logic signed [31:0] score_floor_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	entry_t        rd_data_a;
	entry_t        rd_data_b;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          out_load;
	out_beat_t     out_beat;
	logic          out_free;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q  <= KEEP_COUNT_RST;
			score_floor_q <= SCORE_FLOOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEEP_COUNT:  keep_count_q  <= cfg_data[4:0];
				CFG_SCORE_FLOOR: score_floor_q <= cfg_data;
			endcase
		end
	end

	// Heap sequencer.
	tksel_ctrl #(
		.MAX_KEEP (MAX_KEEP),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_command  (s_axis_tuser),
		.in_entry    (s_axis_tdata),
		.keep_count  (keep_count_q),
		.score_floor (score_floor_q),
		.rd_en       (rd_en),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b),
		.rd_data_a   (rd_data_a),
		.rd_data_b   (rd_data_b),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.out_load    (out_load),
		.out_beat    (out_beat),
		.out_free    (out_free)
	);

	// Heap storage.
	tksel_heap_ram #(
		.MAX_KEEP (MAX_KEEP),
		.AW       (AW)
	) u_ram (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Result register.
	tksel_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.beat   (out_beat),
		.free   (out_free),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata),
		.tlast  (m_axis_tlast),
		.tuser  (m_axis_tuser)
	);

endmodule
